>>> hdl/pip_pkg.sv
// ---------------------------------------------------------------------------
// Point-in-polygon package
// Shared constants, command codes and the tag that travels with each
// vertex word down the edge pipeline.
// ---------------------------------------------------------------------------
package pip_pkg;

    localparam int PIP_MAX_VERTICES = 32;
    localparam int PIP_COORD_BITS   = 32;
    localparam int PIP_CNT_W        = 6;
    localparam int PIP_IDX_W        = 5;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } pip_tag_t;

endpackage

>>> hdl/pip_vtx_mem.sv
// ---------------------------------------------------------------------------
// Vertex store
// One write port and one registered read port over the x and y tables.
// ---------------------------------------------------------------------------
module pip_vtx_mem
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = PIP_MAX_VERTICES,
    parameter int COORD_BITS   = PIP_COORD_BITS,
    localparam int AW          = $clog2(MAX_VERTICES)
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [COORD_BITS-1:0] wr_x,
    input  logic [COORD_BITS-1:0] wr_y,
    input  logic [AW-1:0]         rd_addr,
    output logic [COORD_BITS-1:0] rd_x,
    output logic [COORD_BITS-1:0] rd_y
);

    logic [COORD_BITS-1:0] x_mem [MAX_VERTICES];
    logic [COORD_BITS-1:0] y_mem [MAX_VERTICES];
    logic [COORD_BITS-1:0] rd_x_reg;
    logic [COORD_BITS-1:0] rd_y_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    assign rd_x = rd_x_reg;
    assign rd_y = rd_y_reg;

endmodule

>>> hdl/pip_edge_pipe.sv
// ---------------------------------------------------------------------------
// Edge crossing pipeline
// Takes one vertex word per cycle, pairs it with the previous one to form
// an edge, and folds the crossing test into a running parity bit.
// ---------------------------------------------------------------------------
module pip_edge_pipe
    import pip_pkg::*;
#(
    parameter int COORD_BITS = PIP_COORD_BITS,
    localparam int D         = COORD_BITS + 1,
    localparam int H         = (D + 1) / 2,
    localparam int DH        = D - H,
    localparam int LL_W      = 2 * H + 2,
    localparam int LH_W      = D + 1,
    localparam int HH_W      = 2 * DH,
    localparam int PW        = 2 * D
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  pip_tag_t                     vtx_tag,
    input  logic        [COORD_BITS-1:0] vtx_x,
    input  logic        [COORD_BITS-1:0] vtx_y,
    input  logic signed [COORD_BITS-1:0] pt_x,
    input  logic signed [COORD_BITS-1:0] pt_y,
    output logic                         done,
    output logic                         parity
);

    // Previous vertex: the far end of the edge.
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;

    // Stage 1: differences.
    logic                 e1_valid_reg, e1_last_reg;
    logic                 e1_straddle_reg;
    logic signed [D-1:0]  a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [D-1:0]  a1_next, b1_next, a2_next, b2_next;
    logic                 straddle_next;

    // Stage 2: partial products.
    logic                    e2_valid_reg, e2_last_reg, e2_straddle_reg, e2_dneg_reg;
    logic signed [LL_W-1:0]  ll1_reg, ll2_reg;
    logic signed [LH_W-1:0]  lh1_reg, hl1_reg, lh2_reg, hl2_reg;
    logic signed [HH_W-1:0]  hh1_reg, hh2_reg;

    // Stage 3: full products.
    logic                  e3_valid_reg, e3_last_reg, e3_straddle_reg, e3_dneg_reg;
    logic signed [PW-1:0]  lhs_reg, rhs_reg;

    // Stage 4: parity.
    logic parity_reg;
    logic done_reg;
    logic left;

    logic signed [COORD_BITS-1:0] cur_x, cur_y;

    assign cur_x = $signed(vtx_x);
    assign cur_y = $signed(vtx_y);

    always_ff @(posedge clk)
    begin
        if (vtx_tag.valid)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
    end

    always_comb
    begin
        a1_next = D'(pt_x) - D'(cur_x);
        b1_next = D'(prev_y_reg) - D'(cur_y);
        a2_next = D'(prev_x_reg) - D'(cur_x);
        b2_next = D'(pt_y) - D'(cur_y);
        straddle_next = (cur_y > pt_y) != (prev_y_reg > pt_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
            e1_last_reg  <= 1'b0;
            e2_valid_reg <= 1'b0;
            e2_last_reg  <= 1'b0;
            e3_valid_reg <= 1'b0;
            e3_last_reg  <= 1'b0;
            parity_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            // The first word of a scan only seeds the previous vertex.
            e1_valid_reg <= vtx_tag.valid && !vtx_tag.first;
            e1_last_reg  <= vtx_tag.valid && vtx_tag.last;
            e2_valid_reg <= e1_valid_reg;
            e2_last_reg  <= e1_last_reg;
            e3_valid_reg <= e2_valid_reg;
            e3_last_reg  <= e2_last_reg;
            done_reg     <= e3_last_reg;
            if (clear)
                parity_reg <= 1'b0;
            else if (e3_valid_reg && e3_straddle_reg && left)
                parity_reg <= !parity_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_straddle_reg <= straddle_next;
        a1_reg <= a1_next;
        b1_reg <= b1_next;
        a2_reg <= a2_next;
        b2_reg <= b2_next;

        // Each operand splits into an unsigned low half and a signed high half.
        e2_straddle_reg <= e1_straddle_reg;
        e2_dneg_reg     <= b1_reg[D-1];
        ll1_reg <= $signed({1'b0, a1_reg[H-1:0]}) * $signed({1'b0, b1_reg[H-1:0]});
        lh1_reg <= $signed({1'b0, a1_reg[H-1:0]}) * $signed(b1_reg[D-1:H]);
        hl1_reg <= $signed(a1_reg[D-1:H]) * $signed({1'b0, b1_reg[H-1:0]});
        hh1_reg <= $signed(a1_reg[D-1:H]) * $signed(b1_reg[D-1:H]);
        ll2_reg <= $signed({1'b0, a2_reg[H-1:0]}) * $signed({1'b0, b2_reg[H-1:0]});
        lh2_reg <= $signed({1'b0, a2_reg[H-1:0]}) * $signed(b2_reg[D-1:H]);
        hl2_reg <= $signed(a2_reg[D-1:H]) * $signed({1'b0, b2_reg[H-1:0]});
        hh2_reg <= $signed(a2_reg[D-1:H]) * $signed(b2_reg[D-1:H]);

        e3_straddle_reg <= e2_straddle_reg;
        e3_dneg_reg     <= e2_dneg_reg;
        lhs_reg <= (PW'(hh1_reg) <<< (2 * H)) + ((PW'(lh1_reg) + PW'(hl1_reg)) <<< H)
                   + PW'(ll1_reg);
        rhs_reg <= (PW'(hh2_reg) <<< (2 * H)) + ((PW'(lh2_reg) + PW'(hl2_reg)) <<< H)
                   + PW'(ll2_reg);
    end

    // The edge's y extent is never zero when it straddles, so its sign
    // alone decides which way the cross-multiplied compare points.
    assign left = e3_dneg_reg ? (rhs_reg < lhs_reg) : (lhs_reg < rhs_reg);

    assign done   = done_reg;
    assign parity = parity_reg;

endmodule

>>> hdl/point_in_polygon_test_core.sv
// ---------------------------------------------------------------------------
// Point-in-polygon test core
// Ray casting by crossing parity over a polygon held in the vertex store.
// ---------------------------------------------------------------------------
// Loads may follow one per cycle while no query is in flight. A query over
// n vertices (n = vertex count, clipped to the table) reads n + 1 words,
// one per cycle through the single read port, then drains the edge
// pipeline (an empty polygon skips both); the result is registered once
// any earlier result is taken, and only then is the next word taken.
// Reset clears control state and the vertex count; the tables hold garbage.
module point_in_polygon_test_core
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = PIP_MAX_VERTICES,
    parameter int COORD_BITS   = PIP_COORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [PIP_CNT_W-1:0]         cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [PIP_IDX_W-1:0]         vertex_index,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         inside_res
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic [PIP_CNT_W-1:0] MAX_CLIP = PIP_CNT_W'(MAX_VERTICES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [PIP_CNT_W-1:0]         count_reg;
    logic [PIP_CNT_W-1:0]         n_reg, n_next;
    logic [PIP_CNT_W-1:0]         k_reg, k_next;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic                         out_valid_reg, out_valid_next;
    logic                         inside_res_reg, inside_res_next;
    pip_tag_t                     rd_tag_reg, rd_tag_next;

    logic                 in_fire;
    logic                 query_fire;
    logic                 wr_en;
    logic [AW-1:0]        rd_addr;
    logic [PIP_CNT_W-1:0] n_clip;
    logic [COORD_BITS-1:0] rd_x, rd_y;
    logic                 pipe_done;
    logic                 pipe_inside;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign query_fire = in_fire && (cmd == CMD_QUERY);
    assign wr_en      = in_fire && (cmd == CMD_LOAD)
                        && (32'(vertex_index) < 32'(MAX_VERTICES));
    assign n_clip     = (32'(count_reg) > 32'(MAX_VERTICES)) ? MAX_CLIP : count_reg;

    // Scan order: the last vertex first, then 0 to n-1, so that each word
    // after the first closes an edge with the word before it.
    assign rd_addr = (k_reg == '0) ? AW'(n_reg - PIP_CNT_W'(1))
                                   : AW'(k_reg - PIP_CNT_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        rd_tag_next     = '0;
        out_valid_next  = out_valid_reg && !out_ready;
        inside_res_next = inside_res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (query_fire)
                begin
                    n_next = n_clip;
                    k_next = '0;
                    state_next = (n_clip == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_tag_next.valid = 1'b1;
                rd_tag_next.first = (k_reg == '0);
                rd_tag_next.last  = (k_reg == n_reg);
                k_next = k_reg + PIP_CNT_W'(1);
                if (k_reg == n_reg)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (pipe_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    inside_res_next = pipe_inside;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
            rd_tag_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            rd_tag_reg    <= rd_tag_next;
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_res_reg <= inside_res_next;
        if (query_fire)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_res_reg;

    pip_vtx_mem #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(vertex_index)),
        .wr_x    (coord_x),
        .wr_y    (coord_y),
        .rd_addr (rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    pip_edge_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (query_fire),
        .vtx_tag (rd_tag_reg),
        .vtx_x   (rd_x),
        .vtx_y   (rd_y),
        .pt_x    (px_reg),
        .pt_y    (py_reg),
        .done    (pipe_done),
        .parity  (pipe_inside)
    );

    // The end-of-scan marker only comes back while waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        pipe_done |-> (state_reg == S_DRAIN))
        else $error("scan end seen outside drain");

    // The issue counter never runs past the vertex count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (k_reg <= n_reg))
        else $error("scan counter overran vertex count");

    // An empty polygon goes straight to the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (query_fire && (n_clip == '0)) |=> (state_reg == S_DONE))
        else $error("empty polygon did not finish at once");

    // A scan word is issued only while scanning.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_tag_reg.valid |-> ($past(state_reg) == S_SCAN))
        else $error("read issued outside scan");

endmodule

>>> tb/sv/tb.sv
// ---------------------------------------------------------------------------
// Point-in-polygon core testbench
// Loads polygons into the vertex store and sends query points past them.
// An in-bench crossing-parity predictor supplies the expected inside bit for
// each query word the script leaves untyped. A short script is followed by
// randomized phases at several vertex counts, random stalls on both channels.
// ---------------------------------------------------------------------------
module tb;
    import pip_pkg::*;

    localparam int CW           = PIP_COORD_BITS;
    localparam int DRAIN_CYCLES = PIP_MAX_VERTICES + 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 5000;
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 60;
    localparam int PLAN_ROWS    = 25;

    localparam logic signed [CW-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CW-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [CW-1:0] ONE   = 32'sh0001_0000;

    typedef enum logic [1:0] {ST_LOAD, ST_QUERY, ST_COUNT} step_kind_e;

    typedef struct packed {
        step_kind_e             kind;
        logic [PIP_IDX_W-1:0]   slot;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic [PIP_CNT_W-1:0]   count;
        logic                   typed;
        logic                   result;
    } plan_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [PIP_CNT_W-1:0]         cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic                         cmd;
    logic [PIP_IDX_W-1:0]         vertex_index;
    logic signed [CW-1:0]         coord_x;
    logic signed [CW-1:0]         coord_y;
    logic                         out_valid;
    logic                         out_ready;
    logic                         inside_res;

    // Local copy of the vertex store and the count register.
    logic signed [CW-1:0]         poly_x [PIP_MAX_VERTICES];
    logic signed [CW-1:0]         poly_y [PIP_MAX_VERTICES];
    bit                           slot_loaded [PIP_MAX_VERTICES];
    logic [PIP_CNT_W-1:0]         count_shadow;

    bit                           inside_expected [$];
    bit                           want_bit;
    bit                           calm;
    bit                           hold_req;
    int                           errors;
    int                           n_loads;
    int                           n_queries;
    int                           n_inside;
    int                           n_counts;

    plan_row_t plan [PLAN_ROWS] = '{
        '{ST_COUNT, 5'd0,  32'sd0, 32'sd0, 6'd0, 1'b0, 1'b0},
        // Empty polygon right after reset, then the coordinate extremes.
        '{ST_QUERY, 5'd0,  32'sd0, 32'sd0, 6'd0, 1'b1, 1'b0},
        '{ST_QUERY, 5'd31, C_MAX,  C_MIN,  6'd0, 1'b1, 1'b0},
        '{ST_LOAD,  5'd0,  -ONE,   -ONE,   6'd0, 1'b0, 1'b0},
        '{ST_LOAD,  5'd1,  ONE,    -ONE,   6'd0, 1'b0, 1'b0},
        '{ST_LOAD,  5'd2,  ONE,    ONE,    6'd0, 1'b0, 1'b0},
        '{ST_LOAD,  5'd3,  -ONE,   ONE,    6'd0, 1'b0, 1'b0},
        // A single vertex and a lone segment cannot enclose anything.
        '{ST_COUNT, 5'd0,  32'sd0, 32'sd0, 6'd1, 1'b0, 1'b0},
        '{ST_QUERY, 5'd0,  32'sd0, 32'sd0, 6'd0, 1'b1, 1'b0},
        '{ST_COUNT, 5'd0,  32'sd0, 32'sd0, 6'd2, 1'b0, 1'b0},
        '{ST_QUERY, 5'd0,  32'sd0, 32'sd0, 6'd0, 1'b1, 1'b0},
        '{ST_COUNT, 5'd0,  32'sd0, 32'sd0, 6'd4, 1'b0, 1'b0},
        '{ST_QUERY, 5'd0,  32'sd0, 32'sd0, 6'd0, 1'b1, 1'b1},
        '{ST_QUERY, 5'd0,  2*ONE,  32'sd0, 6'd0, 1'b1, 1'b0},
        // Points on an edge, on a horizontal edge and on a corner.
        '{ST_QUERY, 5'd0,  ONE,    32'sd0, 6'd0, 1'b0, 1'b0},
        '{ST_QUERY, 5'd0,  32'sd0, ONE,    6'd0, 1'b0, 1'b0},
        '{ST_QUERY, 5'd0,  -ONE,   -ONE,   6'd0, 1'b0, 1'b0},
        '{ST_LOAD,  5'd31, C_MAX,  C_MAX,  6'd0, 1'b0, 1'b0},
        '{ST_LOAD,  5'd0,  C_MIN,  C_MIN,  6'd0, 1'b0, 1'b0},
        '{ST_LOAD,  5'd1,  C_MAX,  C_MIN,  6'd0, 1'b0, 1'b0},
        '{ST_LOAD,  5'd2,  32'sd0, C_MAX,  6'd0, 1'b0, 1'b0},
        '{ST_COUNT, 5'd0,  32'sd0, 32'sd0, 6'd3, 1'b0, 1'b0},
        '{ST_QUERY, 5'd0,  32'sd0, 32'sd0, 6'd0, 1'b1, 1'b1},
        '{ST_QUERY, 5'd0,  C_MIN,  C_MIN,  6'd0, 1'b0, 1'b0},
        '{ST_QUERY, 5'd0,  -32'sd1, -32'sd1, 6'd0, 1'b0, 1'b0}
    };

    // A count of -1 picks a random size at run time.
    int phase_count [PHASES] = '{3, 4, 5, 0, 32, 63, 1, 2, -1, -1, 16, 32};
    int phase_mode  [PHASES] = '{0, 1, 0, 2, 1, 3, 0, 0, 1, 2, 0, 1};

    point_in_polygon_test_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .inside_res   (inside_res)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int clipped_count();
        return (count_shadow > PIP_MAX_VERTICES) ? PIP_MAX_VERTICES : int'(count_shadow);
    endfunction

    // Crossing parity over the shadow polygon. The straddling test and the
    // cross-multiplied compare are done at full width, so no rounding occurs.
    function automatic bit crossing_parity(input logic signed [CW-1:0] px,
                                           input logic signed [CW-1:0] py);
        int                   n;
        int                   j;
        bit                   parity;
        bit                   left;
        logic signed [127:0]  qx, qy, xi, yi, xj, yj, d, lhs, rhs;
        n = clipped_count();
        parity = 1'b0;
        qx = px;
        qy = py;
        if (n == 0)
            return 1'b0;
        j = n - 1;
        for (int i = 0; i < n; i++)
        begin
            xi = poly_x[i];
            yi = poly_y[i];
            xj = poly_x[j];
            yj = poly_y[j];
            if ((yi > qy) != (yj > qy))
            begin
                d = yj - yi;
                lhs = (qx - xi) * d;
                rhs = (xj - xi) * (qy - yi);
                left = (d > 0) ? (lhs < rhs) : (rhs < lhs);
                if (left)
                    parity = ~parity;
            end
            j = i;
        end
        return parity;
    endfunction

    function automatic int first_unloaded();
        for (int i = 0; i < clipped_count(); i++)
        begin
            if (!slot_loaded[i])
                return i;
        end
        return -1;
    endfunction

    // Mode 0: tiny grid that lands points on vertices and edges often.
    // Mode 1: within 16 * ONE of zero. Mode 2: anything. Mode 3: corner values.
    function automatic logic signed [CW-1:0] pick_coord(input int mode);
        case (mode)
            0: return int'($urandom_range(0, 32)) - 16;
            1: return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
            2: return $urandom;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return -32'sd1;
                    3: return ONE;
                    default: return 32'sd0;
                endcase
            end
        endcase
    endfunction

    // Present one word and hold it until taken, then update the shadow state.
    task automatic offer_word(input logic c, input logic [PIP_IDX_W-1:0] slot,
                              input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                              input bit typed, input bit typed_val);
        cmd <= c;
        vertex_index <= slot;
        coord_x <= x;
        coord_y <= y;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (c == CMD_LOAD)
        begin
            poly_x[slot] = x;
            poly_y[slot] = y;
            slot_loaded[slot] = 1'b1;
            n_loads++;
        end
        else
        begin
            inside_expected.insert(inside_expected.size(),
                                   typed ? typed_val : crossing_parity(x, y));
            n_queries++;
        end
    endtask

    // The count is only changed once the core has gone quiet.
    task automatic set_count(input logic [PIP_CNT_W-1:0] value);
        in_valid <= 1'b0;
        while (inside_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_shadow = value;
        n_counts++;
    endtask

    // Result side: random stalls, plus one long hold-off on request; always ready when calm.
    initial
    begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_req <= 1'b0;
            end
            else if (calm)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                out_ready <= 1'b1;
                run_left--;
            end
            else
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
                run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 24);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (inside_expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual inside_res=%0b",
                         $time, inside_res);
            end
            else
            begin
                want_bit = inside_expected.pop_front();
                if (inside_res !== want_bit)
                begin
                    errors++;
                    $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                             $time, want_bit, inside_res);
                end
            end
            if (inside_res === 1'b1)
                n_inside++;
        end
    end

    // Watchdog: the run is stuck if no word moves on any channel for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no traffic for %0d cycles", $time, QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int          target;
        int          mode;
        int          gap_slot;
        logic        c;
        logic [4:0]  slot;
        logic signed [CW-1:0] x, y;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_LOAD;
        vertex_index = '0;
        coord_x = '0;
        coord_y = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        count_shadow = '0;
        errors = 0;
        n_loads = 0;
        n_queries = 0;
        n_inside = 0;
        n_counts = 0;
        for (int i = 0; i < PIP_MAX_VERTICES; i++)
        begin
            poly_x[i] = '0;
            poly_y[i] = '0;
            slot_loaded[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            case (plan[r].kind)
                ST_COUNT: set_count(plan[r].count);
                ST_LOAD:  offer_word(CMD_LOAD, plan[r].slot, plan[r].x, plan[r].y, 1'b0, 1'b0);
                default:  offer_word(CMD_QUERY, plan[r].slot, plan[r].x, plan[r].y,
                                     plan[r].typed, plan[r].result);
            endcase
        end

        for (int p = 0; p < PHASES; p++)
        begin
            target = (phase_count[p] < 0) ? $urandom_range(3, 31) : phase_count[p];
            set_count(target[PIP_CNT_W-1:0]);
            calm = (p == PHASES - 1);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                // Partway through one phase the result side stops for a long
                // while; the words keep coming and back up into the core.
                if (p == 2 && k == 20)
                    hold_req <= 1'b1;
                c = ($urandom_range(0, 9) < 3) ? CMD_LOAD : CMD_QUERY;
                slot = $urandom_range(0, PIP_MAX_VERTICES - 1);
                gap_slot = first_unloaded();
                // Never query a polygon that still has an unwritten slot.
                if (c == CMD_QUERY && gap_slot >= 0)
                begin
                    c = CMD_LOAD;
                    slot = gap_slot[4:0];
                end
                mode = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : phase_mode[p];
                x = pick_coord(mode);
                y = pick_coord(mode);
                offer_word(c, slot, x, y, 1'b0, 1'b0);
                if (!calm && $urandom_range(0, 4) == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        while (inside_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (inside_expected.size() != 0)
            errors++;

        $display("Covered %0d vertex loads and %0d point queries (%0d inside)",
                 n_loads, n_queries, n_inside);
        $display("over %0d vertex count settings, including 0, 32 and an oversize count.",
                 n_counts);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
hdl/pip_pkg.sv
hdl/pip_vtx_mem.sv
hdl/pip_edge_pipe.sv
hdl/point_in_polygon_test_core.sv
tb/sv/tb.sv
